### design/arp_pkg.sv
// Shared types, constants and the Pearson hash table for the archive record parser.
`timescale 1ns / 1ps
package arp_pkg;

  localparam int unsigned COUNT_W = 48;

  localparam logic [7:0] MAGIC_RESET = 8'd66;

  // Header field lengths in bytes
  localparam logic [COUNT_W-1:0] MODE_BYTES = 48'd3;
  localparam logic [COUNT_W-1:0] PLEN_BYTES = 48'd2;
  localparam logic [COUNT_W-1:0] CLEN_BYTES = 48'd6;

  // Parser phase, one-hot
  typedef enum logic [6:0] {
    PH_MAGIC = 7'b0000001,
    PH_MODE  = 7'b0000010,
    PH_PLEN  = 7'b0000100,
    PH_CLEN  = 7'b0001000,
    PH_PATH  = 7'b0010000,
    PH_DATA  = 7'b0100000,
    PH_HASH  = 7'b1000000
  } phase_t;

  // Byte classification reported with every result beat
  typedef enum logic [2:0] {
    KIND_MAGIC = 3'd0,
    KIND_MODE  = 3'd1,
    KIND_PLEN  = 3'd2,
    KIND_CLEN  = 3'd3,
    KIND_PATH  = 3'd4,
    KIND_DATA  = 3'd5,
    KIND_HASH  = 3'd6,
    KIND_BAD   = 3'd7
  } kind_t;

  typedef struct packed {
    kind_t              kind;
    logic [7:0]         byte_out;
    logic [COUNT_W-1:0] offset;
    logic [23:0]        mode_value;
    logic [15:0]        path_length;
    logic [COUNT_W-1:0] body_length;
    logic [7:0]         computed_hash;
    logic               hash_ok;
    logic               end_of_record;
  } result_t;

  // Fixed Pearson permutation
  localparam logic [7:0] PEARSON_TABLE [256] = '{
    8'd241, 8'd18,  8'd181, 8'd164, 8'd92,  8'd237, 8'd100, 8'd216,
    8'd183, 8'd107, 8'd2,   8'd12,  8'd43,  8'd246, 8'd90,  8'd143,
    8'd251, 8'd49,  8'd228, 8'd134, 8'd215, 8'd20,  8'd193, 8'd172,
    8'd140, 8'd227, 8'd148, 8'd118, 8'd57,  8'd72,  8'd119, 8'd174,
    8'd78,  8'd14,  8'd97,  8'd3,   8'd208, 8'd252, 8'd11,  8'd195,
    8'd31,  8'd28,  8'd121, 8'd206, 8'd149, 8'd23,  8'd83,  8'd154,
    8'd223, 8'd109, 8'd89,  8'd10,  8'd178, 8'd243, 8'd42,  8'd194,
    8'd221, 8'd131, 8'd212, 8'd94,  8'd205, 8'd240, 8'd161, 8'd7,
    8'd62,  8'd214, 8'd222, 8'd219, 8'd1,   8'd84,  8'd95,  8'd58,
    8'd103, 8'd60,  8'd33,  8'd111, 8'd188, 8'd218, 8'd186, 8'd166,
    8'd146, 8'd189, 8'd201, 8'd155, 8'd68,  8'd145, 8'd44,  8'd163,
    8'd69,  8'd196, 8'd115, 8'd231, 8'd61,  8'd157, 8'd165, 8'd213,
    8'd139, 8'd112, 8'd173, 8'd191, 8'd142, 8'd88,  8'd106, 8'd250,
    8'd8,   8'd127, 8'd26,  8'd126, 8'd0,   8'd96,  8'd52,  8'd182,
    8'd113, 8'd38,  8'd242, 8'd48,  8'd204, 8'd160, 8'd15,  8'd54,
    8'd158, 8'd192, 8'd81,  8'd125, 8'd245, 8'd239, 8'd101, 8'd17,
    8'd136, 8'd110, 8'd24,  8'd53,  8'd132, 8'd117, 8'd102, 8'd153,
    8'd226, 8'd4,   8'd203, 8'd199, 8'd16,  8'd249, 8'd211, 8'd167,
    8'd55,  8'd255, 8'd254, 8'd116, 8'd122, 8'd13,  8'd236, 8'd93,
    8'd144, 8'd86,  8'd59,  8'd76,  8'd150, 8'd162, 8'd207, 8'd77,
    8'd176, 8'd32,  8'd124, 8'd171, 8'd29,  8'd45,  8'd30,  8'd67,
    8'd184, 8'd51,  8'd22,  8'd105, 8'd170, 8'd253, 8'd180, 8'd187,
    8'd130, 8'd156, 8'd98,  8'd159, 8'd220, 8'd40,  8'd133, 8'd135,
    8'd114, 8'd147, 8'd75,  8'd73,  8'd210, 8'd21,  8'd129, 8'd39,
    8'd138, 8'd91,  8'd41,  8'd235, 8'd47,  8'd185, 8'd9,   8'd82,
    8'd64,  8'd87,  8'd244, 8'd50,  8'd74,  8'd233, 8'd175, 8'd247,
    8'd120, 8'd6,   8'd169, 8'd85,  8'd66,  8'd104, 8'd80,  8'd71,
    8'd230, 8'd152, 8'd225, 8'd34,  8'd248, 8'd198, 8'd63,  8'd168,
    8'd179, 8'd141, 8'd137, 8'd5,   8'd19,  8'd79,  8'd232, 8'd128,
    8'd202, 8'd46,  8'd70,  8'd37,  8'd209, 8'd217, 8'd123, 8'd27,
    8'd177, 8'd25,  8'd56,  8'd65,  8'd229, 8'd36,  8'd197, 8'd234,
    8'd108, 8'd35,  8'd151, 8'd238, 8'd200, 8'd224, 8'd99,  8'd190
  };

endpackage

### design/arp_in_stage.sv
// Input register stage: holds one accepted byte until the parser takes it.
`timescale 1ns / 1ps
module arp_in_stage (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] data_byte,
  input  logic       out_free,
  output logic       s1_valid,
  output logic [7:0] s1_byte
);

  logic fire;

  // Stall only while a byte is held and the result side cannot take it
  assign fire     = s1_valid && out_free;
  assign in_stall = s1_valid && !out_free;

  // Load a new beat, or drop the held one once the parser has used it
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_valid && !in_stall) begin
      s1_valid <= 1'b1;
    end else if (fire) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_byte <= data_byte;
    end
  end

endmodule

### design/arp_core.sv
// Record parser state, Pearson hash update and per-byte classification.
`timescale 1ns / 1ps
module arp_core (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [7:0]        cfg_data,
  input  logic              fire,
  input  logic [7:0]        data_byte,
  output arp_pkg::result_t  res
);

  arp_pkg::phase_t                phase, phase_next;
  logic [arp_pkg::COUNT_W-1:0]    field_count, count_next, count_inc;
  logic [23:0]                    mode_reg, mode_next;
  logic [15:0]                    path_len_reg, plen_next;
  logic [arp_pkg::COUNT_W-1:0]    content_len_reg, clen_next, clen_shift;
  logic [7:0]                     running_hash, hash_next, mix;
  logic [7:0]                     magic_value;

  assign count_inc  = field_count + 48'd1;
  assign mix        = arp_pkg::PEARSON_TABLE[running_hash ^ data_byte];
  assign clen_shift = {content_len_reg[39:0], data_byte};

  // Classify the byte and work out the next state
  always_comb begin
    phase_next = phase;
    count_next = field_count;
    mode_next  = mode_reg;
    plen_next  = path_len_reg;
    clen_next  = content_len_reg;
    hash_next  = running_hash;
    res          = '0;
    res.byte_out = data_byte;
    res.kind     = arp_pkg::KIND_BAD;
    unique case (phase)
      arp_pkg::PH_MAGIC: begin
        if (data_byte == magic_value) begin
          res.kind   = arp_pkg::KIND_MAGIC;
          mode_next  = '0;
          plen_next  = '0;
          clen_next  = '0;
          count_next = '0;
          hash_next  = arp_pkg::PEARSON_TABLE[data_byte];
          phase_next = arp_pkg::PH_MODE;
        end
      end
      arp_pkg::PH_MODE: begin
        res.kind   = arp_pkg::KIND_MODE;
        res.offset = field_count;
        hash_next  = mix;
        mode_next  = {mode_reg[15:0], data_byte};
        if (count_inc >= arp_pkg::MODE_BYTES) begin
          count_next = '0;
          phase_next = arp_pkg::PH_PLEN;
        end else begin
          count_next = count_inc;
        end
      end
      arp_pkg::PH_PLEN: begin
        res.kind   = arp_pkg::KIND_PLEN;
        res.offset = field_count;
        hash_next  = mix;
        plen_next  = {path_len_reg[7:0], data_byte};
        if (count_inc >= arp_pkg::PLEN_BYTES) begin
          count_next = '0;
          phase_next = arp_pkg::PH_CLEN;
        end else begin
          count_next = count_inc;
        end
      end
      arp_pkg::PH_CLEN: begin
        res.kind   = arp_pkg::KIND_CLEN;
        res.offset = field_count;
        hash_next  = mix;
        clen_next  = clen_shift;
        if (count_inc >= arp_pkg::CLEN_BYTES) begin
          count_next = '0;
          // Skip empty path and content phases
          if (path_len_reg != 16'd0) begin
            phase_next = arp_pkg::PH_PATH;
          end else if (clen_shift != '0) begin
            phase_next = arp_pkg::PH_DATA;
          end else begin
            phase_next = arp_pkg::PH_HASH;
          end
        end else begin
          count_next = count_inc;
        end
      end
      arp_pkg::PH_PATH: begin
        res.kind   = arp_pkg::KIND_PATH;
        res.offset = field_count;
        hash_next  = mix;
        if (count_inc >= {32'd0, path_len_reg}) begin
          count_next = '0;
          phase_next = (content_len_reg != '0) ? arp_pkg::PH_DATA : arp_pkg::PH_HASH;
        end else begin
          count_next = count_inc;
        end
      end
      arp_pkg::PH_DATA: begin
        res.kind   = arp_pkg::KIND_DATA;
        res.offset = field_count;
        hash_next  = mix;
        if (count_inc >= content_len_reg) begin
          count_next = '0;
          phase_next = arp_pkg::PH_HASH;
        end else begin
          count_next = count_inc;
        end
      end
      arp_pkg::PH_HASH: begin
        res.kind           = arp_pkg::KIND_HASH;
        res.mode_value     = mode_reg;
        res.path_length    = path_len_reg;
        res.body_length    = content_len_reg;
        res.computed_hash  = running_hash;
        res.hash_ok        = (data_byte == running_hash);
        res.end_of_record  = 1'b1;
        count_next         = '0;
        phase_next         = arp_pkg::PH_MAGIC;
      end
      default: begin
        phase_next = arp_pkg::PH_MAGIC;
      end
    endcase
  end

  // Advance state on each beat the parser consumes
  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= arp_pkg::PH_MAGIC;
      field_count     <= '0;
      mode_reg        <= '0;
      path_len_reg    <= '0;
      content_len_reg <= '0;
      running_hash    <= '0;
      magic_value     <= arp_pkg::MAGIC_RESET;
    end else begin
      if (cfg_we) begin
        magic_value <= cfg_data;
      end
      if (fire) begin
        phase           <= phase_next;
        field_count     <= count_next;
        mode_reg        <= mode_next;
        path_len_reg    <= plen_next;
        content_len_reg <= clen_next;
        running_hash    <= hash_next;
      end
    end
  end

`ifndef SYNTHESIS
  a_hash_closes_record: assert property (@(posedge clk) disable iff (rst)
    fire && phase == arp_pkg::PH_HASH |=> phase == arp_pkg::PH_MAGIC && field_count == '0)
    else $error("hash byte did not return the parser to magic");
  a_mode_count: assert property (@(posedge clk) disable iff (rst)
    phase == arp_pkg::PH_MODE |-> field_count < arp_pkg::MODE_BYTES)
    else $error("mode byte count out of range");
  a_path_nonempty: assert property (@(posedge clk) disable iff (rst)
    phase == arp_pkg::PH_PATH |-> path_len_reg != 16'd0 && field_count < {32'd0, path_len_reg})
    else $error("path phase entered with empty or overrun path");
  a_data_nonempty: assert property (@(posedge clk) disable iff (rst)
    phase == arp_pkg::PH_DATA |-> content_len_reg != '0 && field_count < content_len_reg)
    else $error("content phase entered with empty or overrun content");
`endif

endmodule

### design/arp_out_stage.sv
// Result register stage: holds one result beat until the receiver takes it.
`timescale 1ns / 1ps
module arp_out_stage (
  input  logic             clk,
  input  logic             rst,
  input  logic             load,
  input  arp_pkg::result_t res_in,
  output logic             out_free,
  output logic             out_valid,
  input  logic             out_stall,
  output arp_pkg::result_t res_out
);

  assign out_free = !out_valid || !out_stall;

  // Take a new result, or drop the one just delivered
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_out <= res_in;
    end
  end

endmodule

### design/archive_record_parser_pearson_top.sv
// Top level of the archive record parser with 8-bit Pearson hash.
//
//   channel  | handshake                  | payload
//   ---------+----------------------------+------------------------------------------
//   in       | in_valid / in_stall        | data_byte
//   out      | out_valid / out_stall      | kind, byte_out, offset, mode_value,
//            |                            | path_length, body_length,
//            |                            | computed_hash, hash_ok, end_of_record
//   cfg      | cfg_valid / cfg_ready      | cfg_data (magic byte value)
//
// One byte per cycle sustained while out_stall is low; an accepted byte is held in the
// input register, then parsed into the result register that drives the output.
// Synchronous reset clears the parser to expect a magic byte and sets the magic to 66.
// in_stall rises only when a byte is held and the result register is full and stalled.
// cfg_ready is always high; a write lands at the next edge.
`timescale 1ns / 1ps
module archive_record_parser_pearson_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  data_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  kind,
  output logic [7:0]  byte_out,
  output logic [47:0] offset,
  output logic [23:0] mode_value,
  output logic [15:0] path_length,
  output logic [47:0] body_length,
  output logic [7:0]  computed_hash,
  output logic        hash_ok,
  output logic        end_of_record
);

  logic             out_free;
  logic             s1_valid;
  logic [7:0]       s1_byte;
  logic             fire;
  arp_pkg::result_t res_next;
  arp_pkg::result_t res_out;

  assign cfg_ready = 1'b1;
  assign fire      = s1_valid && out_free;

  arp_in_stage u_in (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .data_byte (data_byte),
    .out_free  (out_free),
    .s1_valid  (s1_valid),
    .s1_byte   (s1_byte)
  );

  arp_core u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_data  (cfg_data),
    .fire      (fire),
    .data_byte (s1_byte),
    .res       (res_next)
  );

  arp_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (fire),
    .res_in    (res_next),
    .out_free  (out_free),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .res_out   (res_out)
  );

  // Unpack the result beat onto its ports
  assign kind           = res_out.kind;
  assign byte_out       = res_out.byte_out;
  assign offset         = res_out.offset;
  assign mode_value     = res_out.mode_value;
  assign path_length    = res_out.path_length;
  assign body_length    = res_out.body_length;
  assign computed_hash  = res_out.computed_hash;
  assign hash_ok        = res_out.hash_ok;
  assign end_of_record  = res_out.end_of_record;

`ifndef SYNTHESIS
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall && s1_valid)
    else $error("input stalled without a blocked result");
  a_fire_fills_out: assert property (@(posedge clk) disable iff (rst)
    fire |=> out_valid)
    else $error("parsed beat did not reach the result register");
  a_summary_on_hash_only: assert property (@(posedge clk) disable iff (rst)
    out_valid && res_out.kind != arp_pkg::KIND_HASH |->
      !res_out.end_of_record && !res_out.hash_ok && res_out.computed_hash == 8'd0)
    else $error("record summary on a non-hash beat");
`endif

endmodule
